FILE: hdl/tmam_pkg.sv
// Package for the touch trimmed-mean filter with affine calibration.
// Holds field widths, register indexes, reset values and the output saturation function.
// No dependencies.
`default_nettype none

package tmam_pkg;

  localparam int RAW_W  = 12;
  localparam int MEAN_W = 13;   // trimmed mean never reaches 2*4096
  localparam int COEF_W = 32;
  localparam int PROD_W = COEF_W + MEAN_W + 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam int OUT_W  = 16;
  localparam int IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_COEF_X_FROM_X = 3'd0,
    REG_COEF_X_FROM_Y = 3'd1,
    REG_OFFSET_X      = 3'd2,
    REG_COEF_Y_FROM_X = 3'd3,
    REG_COEF_Y_FROM_Y = 3'd4,
    REG_OFFSET_Y      = 3'd5
  } cfg_reg_e;

  localparam logic signed [COEF_W-1:0] COEF_X_FROM_X_RST = -32'sd424;
  localparam logic signed [COEF_W-1:0] COEF_X_FROM_Y_RST = -32'sd4801;
  localparam logic signed [COEF_W-1:0] OFFSET_X_RST      = 32'sd18373544;
  localparam logic signed [COEF_W-1:0] COEF_Y_FROM_X_RST = 32'sd4907;
  localparam logic signed [COEF_W-1:0] COEF_Y_FROM_Y_RST = 32'sd134;
  localparam logic signed [COEF_W-1:0] OFFSET_Y_RST      = -32'sd428997;

  // Q16.16 to integer, truncated toward zero, clamped to signed 16 bits
  function automatic logic [OUT_W-1:0] sat_q16(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] biased;
    logic signed [31:0]      q;
    biased = acc + (acc[ACC_W-1] ? 48'sd65535 : 48'sd0);
    q      = biased[47:16];
    if (q > 32'sd32767) begin
      sat_q16 = 16'h7FFF;
    end else if (q < -32'sd32768) begin
      sat_q16 = 16'h8000;
    end else begin
      sat_q16 = q[OUT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/touch_trimmed_mean_affine_map.sv
// Top level of the touch trimmed-mean filter with affine calibration.
// Instantiates tmam_front, tmam_fifo and tmam_back; uses tmam_pkg.
//
// Takes one X/Y sample with its pen level per cycle. After WINDOW samples with the
// pen held (the last one may show pen up) it emits one calibrated point; a pen-up
// before that drops the burst. Input throughput is one sample per cycle while the
// two-entry burst queue has room; a burst passes through the queue and the trimmed
// mean, product and sum registers into the saturated output register, and the
// pipeline delivers one point per cycle when the sink keeps up. The user must write
// calibration registers through the cfg port while the block is idle; it does not enforce this.
`default_nettype none

module touch_trimmed_mean_affine_map #(
  parameter int WINDOW = 10
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tmam_pkg::IDX_W-1:0]  cfg_addr_i,
  input  wire logic [tmam_pkg::COEF_W-1:0] cfg_wdata_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [31:0]                 s_axis_tdata,   // raw_x[11:0], raw_y[23:12], pen_down[24]
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [31:0]                      m_axis_tdata    // touch_x[15:0], touch_y[31:16]
);
  import tmam_pkg::*;

  localparam int SUM_W = RAW_W + $clog2(WINDOW);
  localparam int REC_W = 2 * (SUM_W + 2 * RAW_W);

  logic             push, full, rec_valid, rec_pop;
  logic [REC_W-1:0] push_data, rec_data;
  logic [OUT_W-1:0] touch_x, touch_y;

  assign s_axis_tready = !full;

  tmam_front #(.WINDOW(WINDOW), .SUM_W(SUM_W), .REC_W(REC_W)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .raw_x_i     (s_axis_tdata[11:0]),
    .raw_y_i     (s_axis_tdata[23:12]),
    .pen_down_i  (s_axis_tdata[24]),
    .push_o      (push),
    .push_data_o (push_data)
  );

  tmam_fifo #(.WIDTH(REC_W)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .valid_o     (rec_valid),
    .pop_i       (rec_pop),
    .data_o      (rec_data)
  );

  tmam_back #(.WINDOW(WINDOW), .SUM_W(SUM_W), .REC_W(REC_W)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rec_valid_i (rec_valid),
    .rec_data_i  (rec_data),
    .rec_pop_o   (rec_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .touch_x_o   (touch_x),
    .touch_y_o   (touch_y)
  );

  assign m_axis_tdata = {touch_y, touch_x};

endmodule

`default_nettype wire

FILE: hdl/tmam_front.sv
// Front end: accepts samples, tracks per-axis sum/min/max and pushes a finished burst.
// Depends on tmam_pkg.
`default_nettype none

module tmam_front #(
  parameter int WINDOW = 10,
  parameter int SUM_W  = 16,
  parameter int REC_W  = 2 * (SUM_W + 24)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire logic [tmam_pkg::RAW_W-1:0] raw_x_i,
  input  wire logic [tmam_pkg::RAW_W-1:0] raw_y_i,
  input  wire logic                       pen_down_i,
  output logic                            push_o,
  output logic [REC_W-1:0]                push_data_o
);
  import tmam_pkg::*;

  localparam int CNT_W = $clog2(WINDOW + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [RAW_W-1:0] min_x_q, min_x_d, max_x_q, max_x_d;
  logic [RAW_W-1:0] min_y_q, min_y_d, max_y_q, max_y_d;
  logic [SUM_W-1:0] sum_x_n, sum_y_n;
  logic [RAW_W-1:0] min_x_n, max_x_n, min_y_n, max_y_n;
  logic             first, done, accept;

  assign accept = in_valid_i && in_ready_i;
  assign first  = (count_q == '0);
  assign done   = (count_q == CNT_W'(WINDOW - 1));

  always_comb begin
    min_x_n = (first || raw_x_i < min_x_q) ? raw_x_i : min_x_q;
    max_x_n = (first || raw_x_i > max_x_q) ? raw_x_i : max_x_q;
    min_y_n = (first || raw_y_i < min_y_q) ? raw_y_i : min_y_q;
    max_y_n = (first || raw_y_i > max_y_q) ? raw_y_i : max_y_q;
    sum_x_n = sum_x_q + SUM_W'(raw_x_i);
    sum_y_n = sum_y_q + SUM_W'(raw_y_i);
  end

  always_comb begin
    count_d = count_q;
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    min_x_d = min_x_q;
    max_x_d = max_x_q;
    min_y_d = min_y_q;
    max_y_d = max_y_q;
    if (accept) begin
      if (done || !pen_down_i) begin
        // burst finished or pen lifted: start over
        count_d = '0;
        sum_x_d = '0;
        sum_y_d = '0;
        min_x_d = '0;
        max_x_d = '0;
        min_y_d = '0;
        max_y_d = '0;
      end else begin
        count_d = count_q + CNT_W'(1);
        sum_x_d = sum_x_n;
        sum_y_d = sum_y_n;
        min_x_d = min_x_n;
        max_x_d = max_x_n;
        min_y_d = min_y_n;
        max_y_d = max_y_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      min_x_q <= '0;
      max_x_q <= '0;
      min_y_q <= '0;
      max_y_q <= '0;
    end else begin
      count_q <= count_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      min_x_q <= min_x_d;
      max_x_q <= max_x_d;
      min_y_q <= min_y_d;
      max_y_q <= max_y_d;
    end
  end

  assign push_o      = accept && done;
  assign push_data_o = {max_y_n, min_y_n, sum_y_n, max_x_n, min_x_n, sum_x_n};

endmodule

`default_nettype wire

FILE: hdl/tmam_fifo.sv
// Two-entry queue between the sample front end and the calibration pipeline.
// Does not depend on tmam_pkg; generic width.
`default_nettype none

module tmam_fifo #(
  parameter int WIDTH = 80
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tmam_back.sv
// Back end: trimmed mean, affine map and saturation in a four-stage stallable pipeline.
// Also holds the calibration registers. Depends on tmam_pkg.
`default_nettype none

module tmam_back #(
  parameter int WINDOW = 10,
  parameter int SUM_W  = 16,
  parameter int REC_W  = 2 * (SUM_W + 24)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tmam_pkg::IDX_W-1:0]  cfg_addr_i,
  input  wire logic [tmam_pkg::COEF_W-1:0] cfg_wdata_i,
  input  wire logic                        rec_valid_i,
  input  wire logic [REC_W-1:0]            rec_data_i,
  output logic                             rec_pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [tmam_pkg::OUT_W-1:0]       touch_x_o,
  output logic [tmam_pkg::OUT_W-1:0]       touch_y_o
);
  import tmam_pkg::*;

  // floor(log2(WINDOW-2))
  localparam int SHIFT = $clog2(WINDOW - 1) - 1;
  localparam int AX_W  = SUM_W + 2 * RAW_W;

  logic signed [COEF_W-1:0] cxx_q, cxy_q, offx_q, cyx_q, cyy_q, offy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cxx_q  <= COEF_X_FROM_X_RST;
      cxy_q  <= COEF_X_FROM_Y_RST;
      offx_q <= OFFSET_X_RST;
      cyx_q  <= COEF_Y_FROM_X_RST;
      cyy_q  <= COEF_Y_FROM_Y_RST;
      offy_q <= OFFSET_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_COEF_X_FROM_X: cxx_q  <= cfg_wdata_i;
        REG_COEF_X_FROM_Y: cxy_q  <= cfg_wdata_i;
        REG_OFFSET_X:      offx_q <= cfg_wdata_i;
        REG_COEF_Y_FROM_X: cyx_q  <= cfg_wdata_i;
        REG_COEF_Y_FROM_Y: cyy_q  <= cfg_wdata_i;
        REG_OFFSET_Y:      offy_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // unpack burst record: per axis {max, min, sum}
  logic [AX_W-1:0]  rec_x, rec_y;
  logic [SUM_W-1:0] sum_x, sum_y, diff_x, diff_y;
  logic [SUM_W-1:0] shr_x, shr_y;

  assign rec_x  = rec_data_i[AX_W-1:0];
  assign rec_y  = rec_data_i[2*AX_W-1:AX_W];
  assign sum_x  = rec_x[SUM_W-1:0];
  assign sum_y  = rec_y[SUM_W-1:0];
  assign diff_x = sum_x - SUM_W'(rec_x[SUM_W +: RAW_W]) - SUM_W'(rec_x[SUM_W+RAW_W +: RAW_W]);
  assign diff_y = sum_y - SUM_W'(rec_y[SUM_W +: RAW_W]) - SUM_W'(rec_y[SUM_W+RAW_W +: RAW_W]);
  assign shr_x  = diff_x >> SHIFT;
  assign shr_y  = diff_y >> SHIFT;

  // stage valids and ready chain
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_q || out_ready_i;
  assign rdy3      = !v3_q || rdy4;
  assign rdy2      = !v2_q || rdy3;
  assign rdy1      = !v1_q || rdy2;
  assign rec_pop_o = rec_valid_i && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= rec_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  logic [MEAN_W-1:0]        mx_q, my_q;
  logic signed [PROD_W-1:0] pxx_q, pxy_q, pyx_q, pyy_q;
  logic signed [ACC_W-1:0]  accx_q, accy_q;
  logic [OUT_W-1:0]         tx_q, ty_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      mx_q <= shr_x[MEAN_W-1:0];
      my_q <= shr_y[MEAN_W-1:0];
    end
    if (rdy2) begin
      pxx_q <= cxx_q * $signed({1'b0, mx_q});
      pxy_q <= cxy_q * $signed({1'b0, my_q});
      pyx_q <= cyx_q * $signed({1'b0, mx_q});
      pyy_q <= cyy_q * $signed({1'b0, my_q});
    end
    if (rdy3) begin
      accx_q <= ACC_W'(pxx_q) + ACC_W'(pxy_q) + ACC_W'(offx_q);
      accy_q <= ACC_W'(pyx_q) + ACC_W'(pyy_q) + ACC_W'(offy_q);
    end
    if (rdy4) begin
      tx_q <= sat_q16(accx_q);
      ty_q <= sat_q16(accy_q);
    end
  end

  assign out_valid_o = v4_q;
  assign touch_x_o   = tx_q;
  assign touch_y_o   = ty_q;

endmodule

`default_nettype wire

FILE: hdl/tmam_checker.sv
// Port-level checks for touch_trimmed_mean_affine_map, attached with a bind.
// Depends on the top level's port list.
`default_nettype none

module tmam_checker #(
  parameter int WINDOW = 10
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  localparam int SEEN_W = $clog2(WINDOW + 1);

  // samples accepted since reset, saturating at WINDOW
  logic [SEEN_W-1:0] seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (s_axis_tvalid && s_axis_tready && seen_q != SEEN_W'(WINDOW)) begin
      seen_q <= seen_q + SEEN_W'(1);
    end
  end

  // a stalled point holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  // no point can appear before a full window of samples went in
  a_no_early_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> seen_q == SEEN_W'(WINDOW))
    else $error("point emitted before a full window was accepted");

  // reset empties the pipeline
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // with the output idle the queue has drained, so samples are taken
  a_ready_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && !$past(m_axis_tvalid) && !$past(m_axis_tvalid, 2)
      && !$past(m_axis_tvalid, 3) && !$past(m_axis_tvalid, 4)
      && !$past(s_axis_tvalid) && !$past(s_axis_tvalid, 2)
      && !$past(s_axis_tvalid, 3) && !$past(s_axis_tvalid, 4)
      && !$past(s_axis_tvalid, 5) |-> s_axis_tready)
    else $error("input stalled while nothing is in flight");

endmodule

bind touch_trimmed_mean_affine_map tmam_checker #(.WINDOW(WINDOW)) u_tmam_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: dv/touch_point_checker.sv
`timescale 1ns / 100ps
// Checker for touch_trimmed_mean_affine_map: tracks the sample bursts and the
// calibration writes, predicts each touch point and compares it with the output.
// Depends on tmam_pkg.
module touch_point_checker #(
  parameter int WINDOW = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tmam_pkg::IDX_W-1:0]  cfg_addr_i,
  input  logic [tmam_pkg::COEF_W-1:0] cfg_wdata_i,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [31:0]                 s_tdata_i,   // raw_x[11:0], raw_y[23:12], pen_down[24]
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [31:0]                 m_tdata_i,   // touch_x[15:0], touch_y[31:16]
  output int                          points_pending_o,
  output int                          mismatch_count_o
);
  import tmam_pkg::*;

  // floor(log2(WINDOW-2))
  localparam int MEAN_SHIFT = $clog2(WINDOW - 1) - 1;

  typedef struct packed {
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] x;
  } touch_point_t;

  logic signed [COEF_W-1:0] gain_xx, gain_xy, ofs_x;
  logic signed [COEF_W-1:0] gain_yx, gain_yy, ofs_y;
  int unsigned              n_samples;
  logic [31:0]              sum_x, sum_y;
  logic [RAW_W-1:0]         min_x, max_x, min_y, max_y;
  touch_point_t             expected_points[$];

  // Q16.16 affine term, truncated toward zero, clamped to 16 bits
  function automatic logic signed [OUT_W-1:0] calib_axis(
      input logic signed [COEF_W-1:0] ga, gb, ofs, input logic [31:0] ma, mb);
    longint acc, q;
    acc = longint'(ga) * longint'(ma) + longint'(gb) * longint'(mb) + longint'(ofs);
    q   = (acc < 0) ? -((-acc) >>> 16) : (acc >>> 16);
    if (q > 32767) return 16'sh7FFF;
    if (q < -32768) return 16'sh8000;
    return q[OUT_W-1:0];
  endfunction

  task automatic restart_burst();
    n_samples = 0;
    sum_x = '0; min_x = '0; max_x = '0;
    sum_y = '0; min_y = '0; max_y = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [RAW_W-1:0] x, y;
    logic             pen;
    logic [31:0]      mean_x, mean_y;
    touch_point_t     got, want;
    int               errs;
    if (!rst_ni) begin
      gain_xx = COEF_X_FROM_X_RST;
      gain_xy = COEF_X_FROM_Y_RST;
      ofs_x   = OFFSET_X_RST;
      gain_yx = COEF_Y_FROM_X_RST;
      gain_yy = COEF_Y_FROM_Y_RST;
      ofs_y   = OFFSET_Y_RST;
      restart_burst();
      expected_points.delete();
      points_pending_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      errs = 0;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_COEF_X_FROM_X: gain_xx = cfg_wdata_i;
          REG_COEF_X_FROM_Y: gain_xy = cfg_wdata_i;
          REG_OFFSET_X:      ofs_x   = cfg_wdata_i;
          REG_COEF_Y_FROM_X: gain_yx = cfg_wdata_i;
          REG_COEF_Y_FROM_Y: gain_yy = cfg_wdata_i;
          REG_OFFSET_Y:      ofs_y   = cfg_wdata_i;
          default: ;  // unmapped index, no effect
        endcase
      end

      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (expected_points.size() == 0) begin
          $error("unexpected touch point: touch_x %0d, touch_y %0d", got.x, got.y);
          errs++;
        end else begin
          want = expected_points.pop_front();
          if (got.x !== want.x) begin
            $error("touch_x mismatch: expected %0d, got %0d", want.x, got.x);
            errs++;
          end
          if (got.y !== want.y) begin
            $error("touch_y mismatch: expected %0d, got %0d", want.y, got.y);
            errs++;
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        x   = s_tdata_i[RAW_W-1:0];
        y   = s_tdata_i[2*RAW_W-1:RAW_W];
        pen = s_tdata_i[2*RAW_W];
        if (n_samples == 0) begin
          min_x = x; max_x = x;
          min_y = y; max_y = y;
        end else begin
          if (x < min_x) min_x = x;
          if (x > max_x) max_x = x;
          if (y < min_y) min_y = y;
          if (y > max_y) max_y = y;
        end
        sum_x = sum_x + x;
        sum_y = sum_y + y;
        n_samples++;
        if (n_samples >= WINDOW) begin
          // drop one min and one max per axis
          mean_x = (sum_x - min_x - max_x) >> MEAN_SHIFT;
          mean_y = (sum_y - min_y - max_y) >> MEAN_SHIFT;
          want.x = calib_axis(gain_xx, gain_xy, ofs_x, mean_x, mean_y);
          want.y = calib_axis(gain_yx, gain_yy, ofs_y, mean_x, mean_y);
          expected_points.push_back(want);
          restart_burst();
        end else if (!pen) begin
          restart_burst();
        end
      end

      points_pending_o <= expected_points.size();
      mismatch_count_o <= mismatch_count_o + errs;
    end
  end

endmodule

FILE: dv/touch_trimmed_mean_affine_map_tb.sv
`timescale 1ns / 100ps
// Testbench top for touch_trimmed_mean_affine_map: drives sample bursts and
// calibration settings; prediction and comparison live in touch_point_checker.
// Depends on tmam_pkg, the block and touch_point_checker.
module touch_trimmed_mean_affine_map_tb;
  import tmam_pkg::*;

  localparam int WINDOW      = 10;
  localparam int ITEMS       = 1050;
  localparam int PHASES      = 5;
  localparam int SETTLE      = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT_A   = 500;
  localparam int HOLD_AT_B   = 850;

  localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic signed [COEF_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] Q_MIN  = 32'sh8000_0000;
  localparam logic signed [COEF_W-1:0] Q_ZERO = 32'sd0;
  localparam logic signed [COEF_W-1:0] Q_ONE  = 32'sd65536;

  localparam logic [RAW_W-1:0] RAW_MAX = 12'hFFF;
  localparam logic [RAW_W-1:0] RAW_MIN = 12'h000;

  // repeated extremes: three copies each of min and max in X, four each in Y
  localparam logic [RAW_W-1:0] DUP_X [WINDOW] = '{12'd7, 12'd7, 12'd2000, 12'd2000, 12'd7,
                                                  12'd2000, 12'd100, 12'd100, 12'd100, 12'd100};
  localparam logic [RAW_W-1:0] DUP_Y [WINDOW] = '{12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095,
                                                  12'd0, 12'd4095, 12'd0, 12'd2048, 12'd2048};

  typedef enum int {
    CAL_SATURATE,
    CAL_SMALL,
    CAL_WIDE,
    CAL_FLOOR,
    CAL_FINE
  } calib_set_e;

  logic              clk_i     = 1'b0;
  logic              rst_ni;
  logic              cfg_we    = 1'b0;
  logic [IDX_W-1:0]  cfg_addr  = '0;
  logic [COEF_W-1:0] cfg_wdata = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [31:0]       m_tdata;

  int points_pending;
  int mismatch_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs     = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  touch_trimmed_mean_affine_map #(.WINDOW(WINDOW)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  touch_point_checker #(.WINDOW(WINDOW)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_addr_i       (cfg_addr),
    .cfg_wdata_i      (cfg_wdata),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .points_pending_o (points_pending),
    .mismatch_count_o (mismatch_count)
  );

  // sink side: random stalls, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_reqs != hold_served) begin
      hold_served <= hold_reqs;
      hold_left   <= HOLD_CYCLES;
      m_tready    <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [RAW_W-1:0] near(input int center, input int spread);
    int v;
    v = center + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > int'(RAW_MAX)) v = int'(RAW_MAX);
    return v[RAW_W-1:0];
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_q(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  task automatic send_sample(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y,
                             input logic pen);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, pen, y, x};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic load_calib(input logic signed [COEF_W-1:0] gxx, gxy, ox, gyx, gyy, oy);
    write_reg(REG_COEF_X_FROM_X, gxx);
    write_reg(REG_COEF_X_FROM_Y, gxy);
    write_reg(REG_SPARE_6, $urandom);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_COEF_Y_FROM_X, gyx);
    write_reg(REG_COEF_Y_FROM_Y, gyy);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_SPARE_7, $urandom);
    cfg_we <= 1'b0;
  endtask

  // block drained: no point outstanding, pipeline given time to empty
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (points_pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    int   kind, len, spread, cx, cy, sent, phase_items;
    logic last_pen;
    sent = 0;
    // falling edge at time zero fires the asynchronous resets
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct <= 9;
    recv_idle_pct <= 53;

    // full-scale burst, pen already up on the closing sample
    for (int i = 0; i < WINDOW; i++) send_sample(RAW_MAX, RAW_MIN, i != WINDOW - 1);
    // pen lifted on the first sample, then on the second
    send_sample(RAW_MIN, RAW_MAX, 1'b0);
    send_sample(12'd1234, 12'd321, 1'b1);
    send_sample(12'd4000, 12'd5, 1'b0);
    for (int i = 0; i < WINDOW; i++) send_sample(DUP_X[i], DUP_Y[i], 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (calib_set_e'(p))
        CAL_SATURATE: load_calib(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
        CAL_SMALL:    load_calib(rand_q(1 << 17), rand_q(1 << 17), rand_q(1 << 27),
                                 rand_q(1 << 17), rand_q(1 << 17), rand_q(1 << 27));
        CAL_WIDE:     load_calib($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        CAL_FLOOR:    load_calib(Q_MIN, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        default:      load_calib(Q_ONE + rand_q(1 << 12), Q_ZERO, rand_q(1 << 20),
                                 Q_ZERO, Q_ONE - rand_q(1 << 12), rand_q(1 << 20));
      endcase

      phase_items = 0;
      while (phase_items < ITEMS / PHASES) begin
        kind = $urandom_range(99);
        cx   = $urandom_range(int'(RAW_MAX));
        cy   = $urandom_range(int'(RAW_MAX));
        case ($urandom_range(3))
          0:       spread = 0;
          1:       spread = 8;
          2:       spread = 200;
          default: spread = int'(RAW_MAX);
        endcase
        if (kind < 75) begin
          len      = WINDOW;
          last_pen = 1'($urandom_range(1));
        end else if (kind < 90) begin
          len      = $urandom_range(WINDOW - 1, 1);
          last_pen = 1'b0;
        end else begin
          len      = 1;
          last_pen = 1'($urandom_range(1));
        end
        for (int k = 0; k < len; k++) begin
          if (sent == ITEMS / 3) begin
            send_idle_pct <= 53;
            recv_idle_pct <= 9;
          end
          if (sent == 2 * ITEMS / 3) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
          end
          if (sent == HOLD_AT_A || sent == HOLD_AT_B) hold_reqs <= hold_reqs + 1;
          send_sample(near(cx, spread), near(cy, spread), (k == len - 1) ? last_pen : 1'b1);
          sent++;
          phase_items++;
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
